>>> rtl/hcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcp_pkg: shared types and constants of the HDR colour packer
// Stage payload structs, format codes and the rounding shifter.
// ----------------------------------------------------------------------------
package hcp_pkg;

  // output format codes
  localparam logic FMT_R11G11B10 = 1'b0;
  localparam logic FMT_RGB9E5    = 1'b1;

  // clamp limits (binary32 patterns, sign dropped)
  localparam logic [30:0] PF_MAX_BITS  = 31'h4780_0000;  // 65536.0
  localparam logic [30:0] SE_MAX_BITS  = 31'h477F_8000;  // 65408.0
  localparam logic [30:0] SE_FLOOR     = 31'h3780_0000;  // 2^-16
  localparam logic [30:0] SE_EXP_ROUND = 31'h0780_4000;
  localparam logic [30:0] PF_SCALE_SUB = 31'h3800_0000;  // 112 << 23
  localparam logic [7:0]  PF_EXP_LIM   = 8'd112;
  localparam logic [7:0]  PF_SH_BASE   = 8'd113;
  localparam logic [7:0]  RNE_SH_MAX   = 8'd25;

  // stage 1 -> stage 2: clamped channels and the shared-exponent maximum
  typedef struct packed {
    logic        func;
    logic [30:0] red;
    logic [30:0] green;
    logic [30:0] blue;
    logic [30:0] max_ch;
  } clamp_t;

  // stage 2 -> stage 3: scaled channels, shared exponent field
  typedef struct packed {
    logic        func;
    logic [27:0] red;
    logic [27:0] green;
    logic [27:0] blue;
    logic [4:0]  exp_field;
  } scale_t;

  // Right shift with round to nearest, ties to even
  function automatic logic [23:0] rne_shift(input logic [23:0] sig, input logic [7:0] sh);
    logic [48:0] ext;
    logic [23:0] q;
    logic        guard;
    logic        sticky;
    ext    = {sig, 25'b0} >> sh[4:0];
    q      = ext[48:25];
    guard  = ext[24];
    sticky = |ext[23:0];
    if (sh > RNE_SH_MAX) begin
      rne_shift = 24'd0;
    end else begin
      rne_shift = q + {23'd0, guard & (sticky | q[0])};
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/hcp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcp_in_if: input channel of the HDR colour packer
// Valid/ready handshake carrying the format code and three binary32 channels.
// ----------------------------------------------------------------------------
interface hcp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] red_bits;
  logic [31:0] green_bits;
  logic [31:0] blue_bits;

  modport source (output valid, func, red_bits, green_bits, blue_bits, input ready);
  modport sink   (input valid, func, red_bits, green_bits, blue_bits, output ready);
endinterface
`default_nettype wire

>>> rtl/hcp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcp_out_if: output channel of the HDR colour packer
// Valid/ready handshake carrying one packed 32-bit word.
// ----------------------------------------------------------------------------
interface hcp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;

  modport source (output valid, packed_word, input ready);
  modport sink   (input valid, packed_word, output ready);
endinterface
`default_nettype wire

>>> rtl/hcp_clamp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcp_clamp: pipeline stage 1
// Clamps each channel to the mode's range and finds the largest channel, at least 2^-16.
// ----------------------------------------------------------------------------
module hcp_clamp import hcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [31:0] red_bits,
  input  wire logic [31:0] green_bits,
  input  wire logic [31:0] blue_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output clamp_t           out_data
);

  clamp_t      data_next;
  logic [30:0] hi;
  logic [30:0] blue_fl;
  logic [30:0] max_rg;

  function automatic logic [30:0] clamp_ch(input logic [31:0] b, input logic [30:0] lim);
    if (b[31] || (b[30:0] > 31'h7F80_0000)) begin
      clamp_ch = 31'd0;                 // negative or NaN
    end else if (b[30:0] > lim) begin
      clamp_ch = lim;
    end else begin
      clamp_ch = b[30:0];
    end
  endfunction

  // clamp and maximum (positive floats order as integers)
  always_comb begin
    hi               = (func == FMT_RGB9E5) ? SE_MAX_BITS : PF_MAX_BITS;
    data_next.func   = func;
    data_next.red    = clamp_ch(red_bits, hi);
    data_next.green  = clamp_ch(green_bits, hi);
    data_next.blue   = clamp_ch(blue_bits, hi);
    blue_fl          = (data_next.blue > SE_FLOOR) ? data_next.blue : SE_FLOOR;
    max_rg           = (data_next.red > data_next.green) ? data_next.red : data_next.green;
    data_next.max_ch = (blue_fl > max_rg) ? blue_fl : max_rg;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hcp_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcp_scale: pipeline stage 2
// Packed float: scales by 2^-112 with subnormal rounding.
// Shared exponent: derives the bias exponent and aligns each mantissa to it.
// ----------------------------------------------------------------------------
module hcp_scale import hcp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire clamp_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output scale_t      out_data
);

  scale_t      data_next;
  logic [30:0] bias_sum;
  logic [7:0]  exp_b;

  // one channel, either mode
  function automatic logic [27:0] scale_ch(input logic [30:0] c, input logic se,
                                           input logic [7:0] eb);
    logic [7:0]  e;
    logic [7:0]  e_eff;
    logic [23:0] sig;
    logic [30:0] diff;
    e     = c[30:23];
    e_eff = (e == 8'd0) ? 8'd1 : e;
    sig   = {(e != 8'd0), c[22:0]};
    diff  = c - PF_SCALE_SUB;
    if (se) begin
      scale_ch = {4'd0, rne_shift(sig, eb - e_eff)};
    end else if (e > PF_EXP_LIM) begin
      scale_ch = diff[27:0];
    end else begin
      scale_ch = {4'd0, rne_shift(sig, PF_SH_BASE - e_eff)};
    end
  endfunction

  always_comb begin
    bias_sum            = in_data.max_ch + SE_EXP_ROUND;
    exp_b               = bias_sum[30:23];
    data_next.func      = in_data.func;
    data_next.red       = scale_ch(in_data.red,   in_data.func == FMT_RGB9E5, exp_b);
    data_next.green     = scale_ch(in_data.green, in_data.func == FMT_RGB9E5, exp_b);
    data_next.blue      = scale_ch(in_data.blue,  in_data.func == FMT_RGB9E5, exp_b);
    data_next.exp_field = exp_b[4:0] + 5'd2;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hcp_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcp_pack: pipeline stage 3
// Rounds the packed-float fields, assembles the word and holds it as the
// output register.
// ----------------------------------------------------------------------------
module hcp_pack import hcp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   round_to_even,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire scale_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [31:0] packed_word
);

  logic [31:0] word_next;
  logic [27:0] rt;
  logic [27:0] gt;
  logic [27:0] bt;

  function automatic logic [27:0] round11(input logic [27:0] u, input logic even);
    round11 = u + (even ? (28'h000_FFFF + {27'd0, u[16]}) : 28'h001_0000);
  endfunction

  function automatic logic [27:0] round10(input logic [27:0] u, input logic even);
    round10 = u + (even ? (28'h001_FFFF + {27'd0, u[17]}) : 28'h002_0000);
  endfunction

  // field rounding and assembly
  always_comb begin
    rt = round11(in_data.red,   round_to_even);
    gt = round11(in_data.green, round_to_even);
    bt = round10(in_data.blue,  round_to_even);
    if (in_data.func == FMT_RGB9E5) begin
      // a green or blue mantissa that rounded up to 512 spills into the field above
      word_next = {in_data.exp_field, 27'd0}
                | {4'd0, in_data.blue[9:0], 18'd0}
                | {13'd0, in_data.green[9:0], 9'd0}
                | {23'd0, in_data.red[8:0]};
    end else begin
      word_next = {bt[27:18], gt[27:17], rt[27:17]};
    end
  end

  assign in_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      packed_word <= word_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hdr_color_packer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdr_color_packer_unit: R11G11B10 / RGB9E5 colour packer
// Packs three binary32 colour channels into one 32-bit HDR word.
// ----------------------------------------------------------------------------
// Takes one colour per cycle while the output is not stalled and returns each
// packed word through three register stages: clamp and maximum search,
// scaling or exponent alignment with its rounding shifter, then field rounding
// into the output register. Each stage holds while the stage after it is full
// and stalled, so back-pressure at the output reaches the input within the
// same cycle and nothing is dropped. round_to_even selects the packed-float
// rounding and is to be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module hdr_color_packer_unit import hcp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  hcp_in_if.sink    in_ch,
  hcp_out_if.source out_ch
);

  logic   round_to_even;
  logic   s1_valid;
  logic   s1_ready;
  clamp_t s1_data;
  logic   s2_valid;
  logic   s2_ready;
  scale_t s2_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      round_to_even <= 1'b0;
    end else if (cfg_we) begin
      round_to_even <= cfg_wdata;
    end
  end

  hcp_clamp u_clamp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .func       (in_ch.func),
    .red_bits   (in_ch.red_bits),
    .green_bits (in_ch.green_bits),
    .blue_bits  (in_ch.blue_bits),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  hcp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  hcp_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .round_to_even (round_to_even),
    .in_valid      (s2_valid),
    .in_ready      (s2_ready),
    .in_data       (s2_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .packed_word   (out_ch.packed_word)
  );

endmodule
`default_nettype wire
